@@ sv/pft_pkg.sv @@
// Package for the process ID filter table: sizes, operation codes and beat types.
package pft_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH);

  // Operation codes carried in the func field.
  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_QUERY  = 3'd2;
  localparam logic [2:0] FUNC_EXIT   = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  // Input beat.
  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] pid;
    logic [7:0]  index;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic        ok;
    logic        is_protected;
    logic [31:0] entry;
    logic [7:0]  live_count;
  } out_beat_t;

  // Access request from the sequencer to the table memory.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              wr_vld;
    logic              clr_en;
    logic [ADDR_W-1:0] clr_addr;
    logic              flush_en;
    logic [CNT_W-1:0]  flush_cnt;
  } tbl_req_t;

  // Registered read response from the table memory.
  typedef struct packed {
    logic [31:0] rd_data;
    logic        rd_valid;
  } tbl_rsp_t;

endpackage

@@ sv/pft_table.sv @@
// Table memory with one read and one write port, plus valid bits for slots 0 and 1.
module pft_table (
  input  logic              clk,
  input  logic              rst_n,
  input  pft_pkg::tbl_req_t req,
  output pft_pkg::tbl_rsp_t rsp
);

  logic [31:0] mem [pft_pkg::TABLE_DEPTH];
  logic [1:0]  vld_r;
  logic [31:0] rd_data_r;
  logic        rd_valid_r;
  logic        rd_low;
  logic        wr_low;
  logic        clr_low;

  // Slots 0 and 1 are the only ones that are read while above the live count.
  assign rd_low  = (req.rd_addr[pft_pkg::ADDR_W-1:1] == '0);
  assign wr_low  = (req.wr_addr[pft_pkg::ADDR_W-1:1] == '0);
  assign clr_low = (req.clr_addr[pft_pkg::ADDR_W-1:1] == '0);

  // Storage array and registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r  <= mem[req.rd_addr];
      rd_valid_r <= rd_low ? vld_r[req.rd_addr[0]] : 1'b1;
    end
  end

  // Valid bits of slots 0 and 1: a slot that is not valid reads as zero. Every other
  // slot is only read below the live count, so it has always been written since it
  // last fell out of range and needs no valid bit. Reset empties both slots, a flush
  // zeroes those below the given count, and a clear drops one slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (req.wr_en && wr_low) begin
        vld_r[req.wr_addr[0]] <= req.wr_vld;
      end
      if (req.clr_en && clr_low) begin
        vld_r[req.clr_addr[0]] <= 1'b0;
      end
      if (req.flush_en) begin
        if (req.flush_cnt != '0) begin
          vld_r[0] <= 1'b0;
        end
        if (req.flush_cnt > pft_pkg::CNT_W'(1)) begin
          vld_r[1] <= 1'b0;
        end
      end
    end
  end

  assign rsp.rd_data  = rd_data_r;
  assign rsp.rd_valid = rd_valid_r;

endmodule

@@ sv/pft_ctrl.sv @@
// Operation sequencer: decodes a beat, walks the table memory and holds the result.
module pft_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pft_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pft_pkg::out_beat_t out_data,
  output pft_pkg::tbl_req_t  req,
  input  pft_pkg::tbl_rsp_t  rsp
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PROT0  = 9'b000000010,
    S_PROT1  = 9'b000000100,
    S_PROTC  = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_LASTRD = 9'b000100000,
    S_MOVE   = 9'b001000000,
    S_RDWAIT = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t                       state_r,     state_nxt;
  logic [2:0]                   op_r,        op_nxt;
  logic [31:0]                  pid_r,       pid_nxt;
  logic [pft_pkg::CNT_W-1:0]    cnt_r,       cnt_nxt;
  logic [pft_pkg::CNT_W-1:0]    scan_addr_r, scan_addr_nxt;
  logic                         cmp_pend_r,  cmp_pend_nxt;
  logic [pft_pkg::ADDR_W-1:0]   cmp_addr_r,  cmp_addr_nxt;
  logic [pft_pkg::ADDR_W-1:0]   hit_addr_r,  hit_addr_nxt;
  logic                         prot_r,      prot_nxt;
  logic                         res_ok_r,    res_ok_nxt;
  logic                         res_prot_r,  res_prot_nxt;
  logic [31:0]                  res_entry_r, res_entry_nxt;
  logic                         out_valid_r, out_valid_nxt;
  pft_pkg::out_beat_t           out_data_r,  out_data_nxt;

  logic [31:0]                  rdata;
  logic                         hit;
  logic                         prot_all;
  logic [pft_pkg::ADDR_W-1:0]   last_addr;

  // Entries that are not valid read as zero.
  assign rdata     = rsp.rd_valid ? rsp.rd_data : 32'd0;
  assign hit       = cmp_pend_r && (rdata == pid_r);
  assign prot_all  = prot_r || (rdata == pid_r);
  assign last_addr = pft_pkg::ADDR_W'(cnt_r - pft_pkg::CNT_W'(1));
  assign in_stall  = (state_r != S_IDLE);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pid_nxt       = pid_r;
    cnt_nxt       = cnt_r;
    scan_addr_nxt = scan_addr_r;
    cmp_pend_nxt  = cmp_pend_r;
    cmp_addr_nxt  = cmp_addr_r;
    hit_addr_nxt  = hit_addr_r;
    prot_nxt      = prot_r;
    res_ok_nxt    = res_ok_r;
    res_prot_nxt  = res_prot_r;
    res_entry_nxt = res_entry_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    req           = '0;

    // The waiting result leaves when the receiver takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_data.func;
          pid_nxt       = in_data.pid;
          res_ok_nxt    = 1'b0;
          res_prot_nxt  = 1'b0;
          res_entry_nxt = 32'd0;
          scan_addr_nxt = '0;
          cmp_pend_nxt  = 1'b0;
          state_nxt     = S_FIN;
          case (in_data.func)
            pft_pkg::FUNC_ADD: begin
              if (cnt_r < pft_pkg::CNT_W'(pft_pkg::TABLE_DEPTH - 1)) begin
                res_ok_nxt = 1'b1;
                if (in_data.pid == 32'd0) begin
                  cnt_nxt = '0;
                end else begin
                  req.wr_en   = 1'b1;
                  req.wr_addr = pft_pkg::ADDR_W'(cnt_r);
                  req.wr_data = in_data.pid;
                  req.wr_vld  = 1'b1;
                  cnt_nxt     = cnt_r + pft_pkg::CNT_W'(1);
                end
              end
            end
            pft_pkg::FUNC_REMOVE: begin
              if (cnt_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            pft_pkg::FUNC_QUERY, pft_pkg::FUNC_EXIT: begin
              state_nxt = S_PROT0;
            end
            pft_pkg::FUNC_READ: begin
              if (in_data.index < cnt_r) begin
                req.rd_en   = 1'b1;
                req.rd_addr = pft_pkg::ADDR_W'(in_data.index);
                state_nxt   = S_RDWAIT;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // Protection check reads slots 0 and 1.
      S_PROT0: begin
        req.rd_en   = 1'b1;
        req.rd_addr = pft_pkg::ADDR_W'(0);
        state_nxt   = S_PROT1;
      end
      S_PROT1: begin
        req.rd_en   = 1'b1;
        req.rd_addr = pft_pkg::ADDR_W'(1);
        prot_nxt    = (rdata == pid_r);
        state_nxt   = S_PROTC;
      end
      S_PROTC: begin
        res_prot_nxt = prot_all;
        if (op_r == pft_pkg::FUNC_QUERY) begin
          res_ok_nxt = prot_all;
          state_nxt  = S_FIN;
        end else if (prot_all && (cnt_r != '0)) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Scan issues one read per cycle and compares the previous slot's data.
      S_SCAN: begin
        if (hit) begin
          if (cmp_addr_r == '0) begin
            req.flush_en  = 1'b1;
            req.flush_cnt = cnt_r;
            cnt_nxt       = '0;
            res_ok_nxt    = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            hit_addr_nxt = cmp_addr_r;
            state_nxt    = S_LASTRD;
          end
        end else if (cmp_pend_r && (cmp_addr_r == last_addr)) begin
          state_nxt = S_FIN;
        end else if (scan_addr_r < cnt_r) begin
          req.rd_en     = 1'b1;
          req.rd_addr   = pft_pkg::ADDR_W'(scan_addr_r);
          cmp_pend_nxt  = 1'b1;
          cmp_addr_nxt  = pft_pkg::ADDR_W'(scan_addr_r);
          scan_addr_nxt = scan_addr_r + pft_pkg::CNT_W'(1);
        end else begin
          cmp_pend_nxt = 1'b0;
        end
      end

      // Fetch the last live entry, then move it into the freed slot.
      S_LASTRD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = last_addr;
        state_nxt   = S_MOVE;
      end
      S_MOVE: begin
        req.wr_en    = 1'b1;
        req.wr_addr  = hit_addr_r;
        req.wr_data  = rsp.rd_data;
        req.wr_vld   = rsp.rd_valid;
        req.clr_en   = 1'b1;
        req.clr_addr = last_addr;
        cnt_nxt      = cnt_r - pft_pkg::CNT_W'(1);
        res_ok_nxt   = 1'b1;
        state_nxt    = S_FIN;
      end

      S_RDWAIT: begin
        res_entry_nxt = rdata;
        res_ok_nxt    = 1'b1;
        state_nxt     = S_FIN;
      end

      // Load the output register once it is free.
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.ok           = res_ok_r;
          out_data_nxt.is_protected = res_prot_r;
          out_data_nxt.entry        = res_entry_r;
          out_data_nxt.live_count   = 8'(cnt_r);
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cmp_pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pid_r       <= pid_nxt;
    scan_addr_r <= scan_addr_nxt;
    cmp_addr_r  <= cmp_addr_nxt;
    hit_addr_r  <= hit_addr_nxt;
    prot_r      <= prot_nxt;
    res_ok_r    <= res_ok_nxt;
    res_prot_r  <= res_prot_nxt;
    res_entry_r <= res_entry_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/pid_filter_table_top.sv @@
// Top level of the process ID filter table.
//
// The input channel takes one operation beat (func, pid, index) when in_valid
// is high and in_stall is low; the result channel gives one beat per operation
// (ok, is_protected, entry, live_count) when out_valid is high and out_stall low.
// One operation is in flight at a time: in_stall rises after an accepted beat
// and falls when its result has been loaded into the output register.
// An add, an unused code, a read miss or a remove on an empty table go straight
// to the output register. A read first waits for the registered table read, a
// query or process exit first reads slots 0 and 1, and a remove or a protected
// exit scans the live slots through the single read port of the table memory,
// one slot per cycle; a hit past slot 0 moves the last live entry into the freed slot.
// Reset empties the table at once through valid bits on slots 0 and 1, the only
// slots read above the live count, and clears the count; no clearing pass is
// needed. While the receiver stalls, the result beat holds steady and the next
// operation may already be accepted and worked on; it then waits until the
// output register is free.
module pid_filter_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pft_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pft_pkg::out_beat_t out_data
);

  pft_pkg::tbl_req_t req;
  pft_pkg::tbl_rsp_t rsp;

  // Sequencer.
  pft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .req       (req),
    .rsp       (rsp)
  );

  // Table memory.
  pft_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

endmodule

@@ sv/pft_checker.sv @@
// Port-level checker for the process ID filter table, bound to the top level.
module pft_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pft_pkg::out_beat_t out_data
);

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Only one operation is in flight: an accepted beat raises the stall.
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while an operation is in flight");

  // A non-zero entry is only reported by a successful read.
  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.entry != 32'd0) |-> out_data.ok)
    else $error("entry reported without success");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // A protection result never carries a table entry.
  a_prot_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_protected |-> (out_data.entry == 32'd0))
    else $error("entry reported with a protection result");

endmodule

bind pid_filter_table_top pft_checker u_chk (.*);

@@ test/tb.sv @@
// Self-checking testbench for the process ID filter table: directed beats, then random traffic.
module tb;

  // Spare operation codes that the block must ignore.
  localparam logic [2:0] FUNC_SPARE_A = 3'd5;
  localparam logic [2:0] FUNC_SPARE_B = 3'd6;
  localparam logic [2:0] FUNC_SPARE_C = 3'd7;

  localparam bit BY_MODEL = 1'b0;
  localparam bit BY_HAND  = 1'b1;

  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam int FILL_LIMIT  = 2000;

  typedef struct packed {
    pft_pkg::in_beat_t  beat;
    bit                 typed;
    pft_pkg::out_beat_t want;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pft_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  pft_pkg::out_beat_t out_data;

  // Shadow copy of the table and its live count.
  logic [31:0] pid_slots [pft_pkg::TABLE_DEPTH];
  int          live_n;

  pft_pkg::out_beat_t pending_results [$];
  plan_row_t          plan_q [$];
  pft_pkg::out_beat_t head_want;
  int          errors      = 0;
  int          send_pct    = 27;
  int          recv_pct    = 62;
  int          hold_asked  = 0;
  int          hold_done   = 0;

  pid_filter_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock with a period of four units.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // True when slot 0 or slot 1 holds the ID.
  function automatic bit slot_guards(input logic [31:0] pid);
    return (pid_slots[0] == pid) || (pid_slots[1] == pid);
  endfunction

  // Removes the first live copy of the ID; a hit at slot 0 empties the table.
  function automatic bit slot_drop(input logic [31:0] pid);
    int i;
    int j;
    int last;
    for (i = 0; i < live_n; i++) begin
      if (pid_slots[i] == pid) begin
        if (i == 0) begin
          for (j = 0; j < live_n; j++) pid_slots[j] = '0;
          live_n = 0;
        end else begin
          last = live_n - 1;
          pid_slots[i] = pid_slots[last];
          pid_slots[last] = '0;
          live_n = last;
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one operation to the shadow table and returns the result beat it gives.
  function automatic pft_pkg::out_beat_t table_apply(input pft_pkg::in_beat_t b);
    pft_pkg::out_beat_t r;
    r = '0;
    case (b.func)
      pft_pkg::FUNC_ADD: begin
        if (live_n < pft_pkg::TABLE_DEPTH - 1) begin
          r.ok = 1'b1;
          if (b.pid == '0) begin
            live_n = 0;
          end else begin
            pid_slots[live_n] = b.pid;
            live_n++;
          end
        end
      end
      pft_pkg::FUNC_REMOVE: r.ok = slot_drop(b.pid);
      pft_pkg::FUNC_QUERY: begin
        r.is_protected = slot_guards(b.pid);
        r.ok = r.is_protected;
      end
      pft_pkg::FUNC_EXIT: begin
        r.is_protected = slot_guards(b.pid);
        if (r.is_protected) r.ok = slot_drop(b.pid);
      end
      pft_pkg::FUNC_READ: begin
        if (int'(b.index) < live_n) begin
          r.ok = 1'b1;
          r.entry = pid_slots[b.index];
        end
      end
      default: ;
    endcase
    r.live_count = 8'(live_n);
    return r;
  endfunction

  // Draws one random operation, mostly aimed at IDs the table really holds.
  function automatic pft_pkg::in_beat_t draw_op(input int add_pct, input int clear_pct);
    pft_pkg::in_beat_t b;
    int r;
    int s;
    int slot;
    b.func  = pft_pkg::FUNC_READ;
    b.pid   = $urandom;
    b.index = 8'($urandom_range(255, 0));
    r = $urandom_range(99, 0);
    s = $urandom_range(99, 0);
    if (r < add_pct) begin
      b.func = pft_pkg::FUNC_ADD;
      if (s < 2 && clear_pct > 0) b.pid = '0;
      else if (s < 15) b.pid = 32'($urandom_range(6, 1));
    end else begin
      r = $urandom_range(99, 0);
      if (r < 35) begin
        b.func = pft_pkg::FUNC_REMOVE;
        if (s < 70 && live_n > 0) begin
          if ($urandom_range(99, 0) < clear_pct) slot = 0;
          else slot = $urandom_range(live_n - 1, (live_n > 1) ? 1 : 0);
          b.pid = pid_slots[slot];
        end else if (s < 85) begin
          b.pid = 32'($urandom_range(6, 1));
        end
      end else if (r < 50) begin
        b.func = pft_pkg::FUNC_EXIT;
        if (s < clear_pct * 4) b.pid = pid_slots[0];
        else if (s < 50) b.pid = pid_slots[1];
        else if (s < 60) b.pid = 32'($urandom_range(6, 1));
      end else if (r < 65) begin
        b.func = pft_pkg::FUNC_QUERY;
        if (s < 30) b.pid = pid_slots[0];
        else if (s < 60) b.pid = pid_slots[1];
        else if (s < 70) b.pid = '0;
        else if (s < 80) b.pid = 32'($urandom_range(6, 1));
      end else if (r < 95) begin
        if (s < 70) b.index = 8'($urandom_range(live_n, 0));
      end else begin
        if (s < 33) b.func = FUNC_SPARE_A;
        else if (s < 66) b.func = FUNC_SPARE_B;
        else b.func = FUNC_SPARE_C;
      end
    end
    return b;
  endfunction

  // Queues one directed row; the expected beat is only used for rows typed by hand.
  task automatic plan(input logic [2:0] f, input logic [31:0] p, input logic [7:0] idx,
                      input bit typed, input logic ok, input logic prot,
                      input logic [31:0] entry, input logic [7:0] cnt);
    plan_row_t row;
    row.beat.func          = f;
    row.beat.pid           = p;
    row.beat.index         = idx;
    row.typed              = typed;
    row.want.ok            = ok;
    row.want.is_protected  = prot;
    row.want.entry         = entry;
    row.want.live_count    = cnt;
    plan_q.push_back(row);
  endtask

  // Offers one beat after a random gap and records its expected result once taken.
  task automatic offer(input pft_pkg::in_beat_t b, input bit typed,
                       input pft_pkg::out_beat_t want);
    pft_pkg::out_beat_t calc;
    while ($urandom_range(99, 0) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc = table_apply(b);
    pending_results.push_back(typed ? want : calc);
  endtask

  // Stops offering until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall, or a long hold-off when one is asked for.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        out_stall <= ($urandom_range(99, 0) < recv_pct);
      end
    end
  end

  // Compares each result beat with the oldest expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat %h arrived with nothing expected", $time, out_data);
        errors++;
      end else begin
        head_want = pending_results.pop_front();
        if (out_data.ok !== head_want.ok) begin
          $display("%0t: ok expected %0b, got %0b", $time, head_want.ok, out_data.ok);
          errors++;
        end
        if (out_data.is_protected !== head_want.is_protected) begin
          $display("%0t: is_protected expected %0b, got %0b",
                   $time, head_want.is_protected, out_data.is_protected);
          errors++;
        end
        if (out_data.entry !== head_want.entry) begin
          $display("%0t: entry expected %h, got %h", $time, head_want.entry, out_data.entry);
          errors++;
        end
        if (out_data.live_count !== head_want.live_count) begin
          $display("%0t: live_count expected %0d, got %0d",
                   $time, head_want.live_count, out_data.live_count);
          errors++;
        end
      end
    end
  end

  // Ends the run when no beat has moved on either channel for too long.
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("[pid_filter_table_top] ERROR");
    $finish;
  end

  // Stimulus.
  initial begin
    int k;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    live_n   = 0;
    for (k = 0; k < pft_pkg::TABLE_DEPTH; k++) pid_slots[k] = '0;

    // Directed rows: fresh table, extremes, every operation and the corner cases.
    plan(pft_pkg::FUNC_READ,   32'h0000_0000, 8'd0,   BY_HAND,  1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_QUERY,  32'h0000_0000, 8'd0,   BY_HAND,  1'b1, 1'b1, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_REMOVE, 32'h0000_0000, 8'd0,   BY_HAND,  1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_EXIT,   32'h0000_0000, 8'd0,   BY_HAND,  1'b0, 1'b1, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_ADD,    32'hFFFF_FFFF, 8'd0,   BY_HAND,  1'b1, 1'b0, 32'h0, 8'd1);
    plan(pft_pkg::FUNC_ADD,    32'h0000_0001, 8'd255, BY_HAND,  1'b1, 1'b0, 32'h0, 8'd2);
    plan(pft_pkg::FUNC_ADD,    32'hA5A5_A5A5, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_ADD,    32'h5A5A_5A5A, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_READ,   32'h0, 8'd0, BY_HAND, 1'b1, 1'b0, 32'hFFFF_FFFF, 8'd4);
    plan(pft_pkg::FUNC_READ,   32'h0000_0000, 8'd3,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_READ,   32'h0000_0000, 8'd4,   BY_HAND,  1'b0, 1'b0, 32'h0, 8'd4);
    plan(pft_pkg::FUNC_READ,   32'hFFFF_FFFF, 8'd255, BY_HAND,  1'b0, 1'b0, 32'h0, 8'd4);
    plan(pft_pkg::FUNC_QUERY,  32'h0000_0001, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_QUERY,  32'hA5A5_A5A5, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_REMOVE, 32'h0000_0001, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_READ,   32'h0000_0000, 8'd1,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_REMOVE, 32'hDEAD_BEEF, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_EXIT,   32'hA5A5_A5A5, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_EXIT,   32'h5A5A_5A5A, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(FUNC_SPARE_A,         32'hFFFF_FFFF, 8'd255, BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(FUNC_SPARE_B,         32'hFFFF_FFFF, 8'd255, BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(FUNC_SPARE_C,         32'hFFFF_FFFF, 8'd255, BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    // Adding ID zero empties the count but leaves slot 0 stale for the query.
    plan(pft_pkg::FUNC_ADD,    32'h0000_0000, 8'd0,   BY_HAND,  1'b1, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_QUERY,  32'hFFFF_FFFF, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_ADD,    32'h1234_5678, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);
    plan(pft_pkg::FUNC_REMOVE, 32'h1234_5678, 8'd0,   BY_MODEL, 1'b0, 1'b0, 32'h0, 8'd0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < plan_q.size(); k++) offer(plan_q[k].beat, plan_q[k].typed, plan_q[k].want);

    // Mixed traffic with a long result hold-off part way through.
    for (k = 0; k < 450; k++) begin
      if (k == 200) hold_asked++;
      offer(draw_op(45, 8), BY_MODEL, '0);
    end
    drain_results();

    // Roles swapped: fill the table to the brim, then work it while full.
    send_pct = 62;
    recv_pct = 27;
    for (k = 0; (k < FILL_LIMIT) && (live_n < pft_pkg::TABLE_DEPTH - 1); k++) begin
      offer(draw_op(92, 0), BY_MODEL, '0);
    end
    for (k = 0; k < 400; k++) begin
      if (k == 50) hold_asked++;
      offer(draw_op(55, 2), BY_MODEL, '0);
    end
    drain_results();

    // Back to back on both sides.
    send_pct = 0;
    recv_pct = 0;
    for (k = 0; k < 300; k++) offer(draw_op(40, 10), BY_MODEL, '0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[pid_filter_table_top] OK");
    end else begin
      $display("[pid_filter_table_top] ERROR");
    end
    $finish;
  end

endmodule
